>>> rtl/core/ncs_pkg.sv
package ncs_pkg;

  // default sizing
  localparam int DEF_NODE_CAPACITY = 1024;
  localparam int DEF_MAX_JOINTS    = 6;

  // fixed field widths
  localparam int INPUT_JOINTS = 6;
  localparam int JOINT_W      = 16;
  localparam int DIFF_W       = JOINT_W + 1;
  localparam int SQ_W         = 32;
  localparam int DIST_W       = 37;
  localparam int NI_W         = 10;
  localparam int ST_W         = 2;
  localparam int CMD_W        = 2;
  localparam int ACT_W        = 3;
  localparam int LCNT_W       = 4;
  localparam int IN_DATA_W    = INPUT_JOINTS * JOINT_W;
  localparam int OUT_DATA_W   = 48;

  localparam logic [ACT_W-1:0] ACT_RESET = 3'd6;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DONE
  } state_t;

  // tag that travels with each node through the scan pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } ctl_t;

endpackage

>>> rtl/core/nearest_config_search.sv
// nearest_config_search: node table with brute-force nearest-node search
//
// in channel (in_tvalid/in_tready): one command per transfer, in_tuser holds
// the command (insert, query, clear), in_tdata the six joint angles.
// out channel (out_tvalid/out_tready): exactly one result per command, in
// order; out_tdata holds node index and squared distance, out_tuser status.
// cfg channel (cfg_valid/cfg_ready): writes active_joints, always ready;
// write it only while the block is idle.
//
// one command at a time. insert, clear and unused codes load the result
// register on the input transfer, then the output register. for a query over
// N stored nodes the node memory is read one node per cycle on its single
// read port, then two lane stages, two merge stages and the result and output
// registers follow. an empty-table query finishes like an insert.
// a finished result sits in the output register; the next command is taken
// while it waits, and that command's result is held internally until the
// receiver takes the earlier one.
// reset (rst_n low, synchronous) empties the table, sets active_joints to 6
// and drops any pending result. node memory contents are not cleared.
module nearest_config_search
  import ncs_pkg::*;
#(
  parameter int NODE_CAPACITY = DEF_NODE_CAPACITY,
  parameter int MAX_JOINTS    = DEF_MAX_JOINTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // joint_a[15:0], joint_b, joint_c, joint_d, joint_e, joint_f[95:80]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // node_index[9:0], distance[46:10], zero pad[47]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [ST_W-1:0]       out_tuser,
  // configuration: active_joints
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [ACT_W-1:0]      cfg_data
);

  localparam int IDX_W   = $clog2(NODE_CAPACITY);
  localparam int CNT_W   = $clog2(NODE_CAPACITY + 1);
  localparam int LANE_LIM = (MAX_JOINTS < INPUT_JOINTS) ? MAX_JOINTS : INPUT_JOINTS;

  typedef logic [MAX_JOINTS-1:0][JOINT_W-1:0] joints_t;

  state_t           state_r, state_nxt;
  logic [ACT_W-1:0] active_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] rd_addr_r;
  joints_t          q_r;
  logic [MAX_JOINTS-1:0] mask_r;

  // node memory: one write port, one registered read port
  joints_t          node_store_r [NODE_CAPACITY];
  joints_t          rd_data_r;
  joints_t          in_joints;

  // scan pipeline tags: memory data, lane diff, lane square
  ctl_t             ctl_r [3];
  logic [IDX_W-1:0] idx_r [3];

  logic [MAX_JOINTS-1:0][SQ_W-1:0] sq;
  logic              mg_done;
  logic [IDX_W-1:0]  mg_idx;
  logic [DIST_W-1:0] mg_dist;

  // pending result and output register
  logic [NI_W-1:0]   res_idx_r;
  logic [DIST_W-1:0] res_dist_r;
  logic [ST_W-1:0]   res_st_r;
  logic              out_valid_r;
  logic [NI_W-1:0]   out_idx_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [ST_W-1:0]   out_st_r;

  logic              in_xfer;
  logic              scan_issue;
  logic              last_issue;
  logic              out_free;
  logic              load_out;
  logic              table_full;
  logic              table_empty;
  logic [LCNT_W-1:0] lane_cnt;
  logic [MAX_JOINTS-1:0] mask_nxt;

  assign cfg_ready   = 1'b1;
  assign in_xfer     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign table_full  = (count_r == CNT_W'(NODE_CAPACITY));
  assign table_empty = (count_r == '0);

  // lanes past the input joints are stored as zero
  always_comb begin
    for (int j = 0; j < MAX_JOINTS; j++) begin
      if (j < INPUT_JOINTS) begin
        in_joints[j] = in_tdata[j*JOINT_W +: JOINT_W];
      end else begin
        in_joints[j] = '0;
      end
    end
  end

  // active lane count, clamped to one up to the usable lane limit
  always_comb begin
    lane_cnt = LCNT_W'(active_r);
    if (lane_cnt < LCNT_W'(1)) begin
      lane_cnt = LCNT_W'(1);
    end
    if (lane_cnt > LCNT_W'(LANE_LIM)) begin
      lane_cnt = LCNT_W'(LANE_LIM);
    end
    for (int j = 0; j < MAX_JOINTS; j++) begin
      mask_nxt[j] = LCNT_W'(j) < lane_cnt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_QUERY && !table_empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (last_issue) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (mg_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    scan_issue = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      S_IDLE:  in_tready  = 1'b1;
      S_SCAN:  scan_issue = 1'b1;
      S_DONE:  load_out   = out_free;
      default: ;
    endcase
  end

  assign last_issue = scan_issue && (CNT_W'(rd_addr_r) == count_r - CNT_W'(1));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        ctl_r[s] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
      if (in_xfer) begin
        case (in_tuser)
          CMD_INSERT: begin
            if (!table_full) begin
              count_r <= count_r + CNT_W'(1);
            end
          end
          CMD_CLEAR: count_r <= '0;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      ctl_r[0] <= '{valid: scan_issue, first: (rd_addr_r == '0), last: last_issue};
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
    end
  end

  // node memory
  always_ff @(posedge clk) begin
    if (in_xfer && in_tuser == CMD_INSERT && !table_full) begin
      node_store_r[count_r[IDX_W-1:0]] <= in_joints;
    end
    rd_data_r <= node_store_r[rd_addr_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r[0] <= rd_addr_r;
    idx_r[1] <= idx_r[0];
    idx_r[2] <= idx_r[1];
    if (scan_issue) begin
      rd_addr_r <= rd_addr_r + IDX_W'(1);
    end
    if (in_xfer) begin
      case (in_tuser)
        CMD_INSERT: begin
          res_idx_r  <= table_full ? '0 : NI_W'(count_r);
          res_dist_r <= '0;
          res_st_r   <= table_full ? ST_FULL : ST_OK;
        end
        CMD_QUERY: begin
          res_idx_r  <= '0;
          res_dist_r <= '0;
          res_st_r   <= table_empty ? ST_EMPTY : ST_OK;
          q_r        <= in_joints;
          mask_r     <= mask_nxt;
          rd_addr_r  <= '0;
        end
        default: begin
          res_idx_r  <= '0;
          res_dist_r <= '0;
          res_st_r   <= ST_OK;
        end
      endcase
    end else if (state_r == S_FLUSH && mg_done) begin
      res_idx_r  <= NI_W'(mg_idx);
      res_dist_r <= mg_dist;
      res_st_r   <= ST_OK;
    end
    if (load_out) begin
      out_idx_r  <= res_idx_r;
      out_dist_r <= res_dist_r;
      out_st_r   <= res_st_r;
    end
  end

  // one squared-difference lane per joint
  for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
    ncs_lane u_lane (
      .clk     (clk),
      .lane_en (mask_r[j]),
      .q       (q_r[j]),
      .n       (rd_data_r[j]),
      .sq      (sq[j])
    );
  end

  ncs_merge #(
    .MAX_JOINTS (MAX_JOINTS),
    .IDX_W      (IDX_W)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (ctl_r[2]),
    .in_idx    (idx_r[2]),
    .sq        (sq),
    .done      (mg_done),
    .best_idx  (mg_idx),
    .best_dist (mg_dist)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - DIST_W - NI_W){1'b0}}, out_dist_r, out_idx_r};
  assign out_tuser  = out_st_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NODE_CAPACITY))
    else $error("node count beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> CNT_W'(rd_addr_r) < count_r)
    else $error("scan reads past stored nodes");

  a_done_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    mg_done |-> state_r == S_FLUSH)
    else $error("merge finished outside flush");

  a_flush_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && state_nxt != S_FLUSH) |-> mg_done)
    else $error("flush left before merge finished");
`endif

endmodule

>>> rtl/core/ncs_lane.sv
module ncs_lane
  import ncs_pkg::*;
(
  input  logic                      clk,
  input  logic                      lane_en,
  input  logic signed [JOINT_W-1:0] q,
  input  logic signed [JOINT_W-1:0] n,
  output logic        [SQ_W-1:0]    sq
);

  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [DIFF_W-1:0]   diff_nxt;
  logic                       en_r;
  logic signed [2*DIFF_W-1:0] prod;
  logic        [SQ_W-1:0]     sq_r;
  logic        [SQ_W-1:0]     sq_nxt;

  // exact 17-bit difference
  assign diff_nxt = DIFF_W'(q) - DIFF_W'(n);

  // square always fits in 32 bits unsigned
  assign prod   = diff_r * diff_r;
  assign sq_nxt = en_r ? prod[SQ_W-1:0] : '0;

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    en_r   <= lane_en;
    sq_r   <= sq_nxt;
  end

  assign sq = sq_r;

endmodule

>>> rtl/core/ncs_merge.sv
module ncs_merge
  import ncs_pkg::*;
#(
  parameter int MAX_JOINTS = DEF_MAX_JOINTS,
  parameter int IDX_W      = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ctl_t                             in_ctl,
  input  logic [IDX_W-1:0]                 in_idx,
  input  logic [MAX_JOINTS-1:0][SQ_W-1:0]  sq,
  output logic                             done,
  output logic [IDX_W-1:0]                 best_idx,
  output logic [DIST_W-1:0]                best_dist
);

  ctl_t              ctl_s_r;
  logic [IDX_W-1:0]  idx_s_r;
  logic [DIST_W-1:0] sum_s_r;
  logic [DIST_W-1:0] sum_nxt;
  logic [IDX_W-1:0]  best_idx_r;
  logic [DIST_W-1:0] best_dist_r;
  logic              take;
  logic              done_r;

  // lane sum, exact over all lanes
  always_comb begin
    sum_nxt = '0;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      sum_nxt = sum_nxt + DIST_W'(sq[j]);
    end
  end

  // strictly smaller wins, so ties keep the lower index
  assign take = ctl_s_r.valid && (ctl_s_r.first || (sum_s_r < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s_r <= '0;
      done_r  <= 1'b0;
    end else begin
      ctl_s_r <= in_ctl;
      done_r  <= ctl_s_r.valid && ctl_s_r.last;
    end
  end

  always_ff @(posedge clk) begin
    idx_s_r <= in_idx;
    sum_s_r <= sum_nxt;
    if (take) begin
      best_idx_r  <= idx_s_r;
      best_dist_r <= sum_s_r;
    end
  end

  assign done      = done_r;
  assign best_idx  = best_idx_r;
  assign best_dist = best_dist_r;

endmodule

>>> tb/tb_nearest_config_search.sv
`timescale 1ns / 1ps

module tb_nearest_config_search;
  import ncs_pkg::*;

  localparam int NODE_CAP = DEF_NODE_CAPACITY;
  // command code with no operation behind it, answered with an all-zero ok result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // cycles with no transfer on any channel before the run is declared hung
  localparam int IDLE_LIMIT = 20000;
  // drain time after the last expected result
  localparam int TAIL_CYCLES = 16;

  typedef logic [INPUT_JOINTS-1:0][JOINT_W-1:0] pose_t;

  // one command as it travels on the input channel
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    pose_t            pose;
  } command_t;

  // one result as it travels on the output channel
  typedef struct packed {
    logic [NI_W-1:0]   node_index;
    logic [DIST_W-1:0] distance;
    logic [ST_W-1:0]   status;
  } nearest_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // joint_a[15:0] .. joint_f[95:80]
  logic [CMD_W-1:0]      in_tuser = '0;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // node_index[9:0], distance[46:10], pad[47]
  logic [ST_W-1:0]       out_tuser;       // status[1:0]
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [ACT_W-1:0]      cfg_data = '0;

  nearest_config_search #(
    .NODE_CAPACITY(NODE_CAP),
    .MAX_JOINTS   (DEF_MAX_JOINTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: private copy of the node table, node count and lane setting
  // ---------------------------------------------------------------------------
  pose_t            node_table [NODE_CAP];
  int               node_total = 0;
  logic [ACT_W-1:0] lane_setting = ACT_RESET;
  nearest_t         results_due [$];   // expected results, oldest first
  int               mismatches = 0;

  // update the table for one accepted command and queue the result it must give
  task automatic apply_command(input command_t c);
    nearest_t                 r;
    int                       lanes;
    logic signed [DIFF_W-1:0] diff;
    logic [SQ_W-1:0]          sq;
    logic [DIST_W-1:0]        d;
    r = '0;
    // lane setting 0 acts as one lane, anything above the joint count saturates
    lanes = (lane_setting == 0) ? 1 :
            (lane_setting > DEF_MAX_JOINTS) ? DEF_MAX_JOINTS : lane_setting;
    case (c.cmd)
      CMD_INSERT: begin
        if (node_total >= NODE_CAP) begin
          r.status = ST_FULL;            // nothing stored
        end else begin
          node_table[node_total] = c.pose;
          r.node_index = NI_W'(node_total);
          node_total++;
        end
      end
      CMD_QUERY: begin
        if (node_total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < node_total; i++) begin
            d = '0;
            for (int j = 0; j < lanes; j++) begin
              diff = $signed(c.pose[j]) - $signed(node_table[i][j]);
              sq = diff * diff;            // exact, fits 32 bits
              d = d + DIST_W'(sq);
            end
            // strictly smaller needed, so ties keep the lowest index
            if (i == 0 || d < r.distance) begin
              r.distance = d;
              r.node_index = NI_W'(i);
            end
          end
        end
      end
      CMD_CLEAR: node_total = 0;
      default: ;                          // unused code leaves the table alone
    endcase
    results_due = {results_due, r};
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of transfers with random gaps, fed from cmd_backlog
  // ---------------------------------------------------------------------------
  command_t cmd_backlog [$];
  command_t cmd_on_bus;
  int       burst_left = 0;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      // predict at the edge the transfer happens
      if (in_tvalid && in_tready) apply_command(cmd_on_bus);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cmd_on_bus = cmd_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cmd_on_bus.pose;
          in_tuser  <= cmd_on_bus.cmd;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a third of the bursts run back to back with no gap after them
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each result transfer with the oldest expectation;
  // out_tready follows one of four stall patterns, picked anew at random.
  // ---------------------------------------------------------------------------
  int       stall_mode = 0;
  int       mon_cycle = 0;
  nearest_t want;

  task automatic report_mismatch(input string field, input longint unsigned exp_v,
                                 input longint unsigned act_v);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t ns: result transfer with none expected, actual index %0d dist %0d st %0d",
                 $time, out_tdata[NI_W-1:0], out_tdata[NI_W +: DIST_W], out_tuser);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_tdata[NI_W-1:0] !== want.node_index)
          report_mismatch("node_index", want.node_index, out_tdata[NI_W-1:0]);
        if (out_tdata[NI_W +: DIST_W] !== want.distance)
          report_mismatch("distance", want.distance, out_tdata[NI_W +: DIST_W]);
        if (out_tuser !== want.status)
          report_mismatch("status", want.status, out_tuser);
      end
    end
    mon_cycle++;
    if (mon_cycle % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;                                // never stalls
      1: out_tready <= ($urandom_range(0, 2) != 0);         // light random stalls
      2: out_tready <= ((mon_cycle % 9) >= 5);              // periodic stall window
      default: out_tready <= ($urandom_range(0, 3) == 0);   // heavy back-pressure
    endcase
  end

  // watchdog: a run that stops moving counts as a failure
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  int tracked_nodes = 0;   // node count as the stimulus side sees it

  task automatic send(input logic [CMD_W-1:0] code, input pose_t p);
    command_t c;
    c.cmd = code;
    c.pose = p;
    cmd_backlog = {cmd_backlog, c};
  endtask

  // block idle: nothing queued, nothing on the bus, no result outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_tvalid || results_due.size() != 0);
  endtask

  task automatic write_active_joints(input logic [ACT_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    lane_setting = v;
    cfg_valid <= 1'b0;
  endtask

  // angles lean toward the extremes and toward zero
  function automatic logic [JOINT_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return JOINT_W'($urandom_range(0, 64)) - 16'd32;
      default: return JOINT_W'($urandom);
    endcase
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    for (int j = 0; j < INPUT_JOINTS; j++) p[j] = pick_angle();
    return p;
  endfunction

  // small per-lane offsets, so the nearest node is close and near-ties appear
  function automatic pose_t near_pose(input pose_t p);
    pose_t q;
    for (int j = 0; j < INPUT_JOINTS; j++)
      q[j] = p[j] + JOINT_W'($urandom_range(0, 16)) - 16'd8;
    return q;
  endfunction

  // mostly insert runs followed by queries; the rest is noise with any code
  task automatic random_traffic(input int n_items);
    int               made;
    pose_t            p;
    pose_t            pool [$];
    logic [CMD_W-1:0] code;
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        if (tracked_nodes > 120 || $urandom_range(0, 3) == 0) begin
          send(CMD_CLEAR, random_pose());
          tracked_nodes = 0;
          pool.delete();
          made++;
        end
        repeat ($urandom_range(1, 10)) begin
          // repeated poses give exact distance ties
          p = (pool.size() != 0 && $urandom_range(0, 4) == 0) ?
              pool[$urandom_range(0, pool.size() - 1)] : random_pose();
          send(CMD_INSERT, p);
          pool = {pool, p};
          tracked_nodes++;
          made++;
        end
        repeat ($urandom_range(1, 6)) begin
          p = ($urandom_range(0, 2) != 0) ?
              near_pose(pool[$urandom_range(0, pool.size() - 1)]) : random_pose();
          send(CMD_QUERY, p);
          made++;
        end
      end else begin
        code = CMD_W'($urandom_range(0, 3));
        p = random_pose();
        send(code, p);
        if (code == CMD_INSERT) begin
          pool = {pool, p};
          tracked_nodes++;
        end else if (code == CMD_CLEAR) begin
          pool.delete();
          tracked_nodes = 0;
        end
        made++;
      end
      // now and then the sender holds off until every result is back
      if ($urandom_range(0, 24) == 0) wait_drained();
    end
  endtask

  logic [ACT_W-1:0] lane_plan [8] = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd6, 3'd2, 3'd5, 3'd4};

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, all lanes active from reset
    send(CMD_QUERY, random_pose());          // empty table
    send(CMD_CLEAR, '0);                     // clear on an empty table
    send(CMD_UNUSED, '1);                    // unused code
    send(CMD_INSERT, {6{16'h7FFF}});
    send(CMD_INSERT, {6{16'h8000}});
    send(CMD_INSERT, '0);
    send(CMD_INSERT, '0);                    // duplicate, tie with the previous node
    send(CMD_INSERT, {6{16'h5555}});
    send(CMD_INSERT, {6{16'hAAAA}});
    send(CMD_QUERY, {6{16'h7FFF}});
    send(CMD_QUERY, {6{16'h8000}});
    send(CMD_QUERY, '0);                     // tie keeps the lower index
    send(CMD_QUERY, {6{16'h0001}});
    send(CMD_UNUSED, random_pose());         // must not disturb the table
    send(CMD_QUERY, random_pose());
    send(CMD_CLEAR, '1);
    send(CMD_QUERY, {6{16'h7FFF}});          // empty again after clear
    send(CMD_INSERT, {6{16'h8000}});
    send(CMD_QUERY, {6{16'h7FFF}});          // largest possible distance
    send(CMD_INSERT, {6{16'h7FFF}});
    send(CMD_QUERY, '0);
    wait_drained();

    send(CMD_CLEAR, '0);
    tracked_nodes = 0;

    // random part, one phase per lane setting, extremes and out-of-range included
    foreach (lane_plan[k]) begin
      write_active_joints(lane_plan[k]);
      random_traffic(66);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
